/* rtl/qrs_pkg.sv */
// Shared types, widths and constants of the quadratic root solver.
package qrs_pkg;

  // Fraction bits of the coefficient and root format.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned THR_W     = 32;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(4295);

  // Discriminant magnitude and its square root.
  localparam int unsigned ROOT_W = COEF_W + 1;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;

  // Numerator -b +/- s, its magnitude, divisor 2|a| and quotient.
  localparam int unsigned NUM_W = ROOT_W + 2;
  localparam int unsigned NM_W  = NUM_W - 1;
  localparam int unsigned DEN_W = COEF_W + 1;
  localparam int unsigned QUO_W = COEF_W - 1;
  localparam int unsigned N_W   = NM_W + FRAC_BITS;
  localparam int unsigned HI_W  = N_W - QUO_W;

  localparam logic [COEF_W-1:0] ROOT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] ROOT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_EQUAL = 2'd1,
    KIND_TWO   = 2'd2
  } kind_e;

  // Per-word data that rides along with the arithmetic.
  typedef struct packed {
    logic                     zero;
    kind_e                    kind;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
  } side_t;

endpackage

/* rtl/qrs_disc.sv */
// Discriminant: squares and products, exact b*b-4ac, threshold classification.
module qrs_disc import qrs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [COEF_W-1:0] coef_a_i,
  input  logic signed [COEF_W-1:0] coef_b_i,
  input  logic signed [COEF_W-1:0] coef_c_i,
  input  logic [THR_W-1:0]         thr_i,
  output logic                     valid_o,
  output logic [RAD_W-1:0]         rad_o,
  output side_t                    sb_o
);

  logic [COEF_W-1:0]   am, bm, cm;
  logic [2*COEF_W-1:0] bb_d, p_d, bb_q, p_q;
  logic                neg4ac_d, neg4ac_q;
  side_t               sb1_d, sb1_q, sb2_d, sb2_q;
  logic                v1_q, v2_q;
  logic [RAD_W-1:0]    p4, bbx, mag, thrx, rad_d, rad_q;
  logic                dneg;

  // Stage 1: magnitudes and the two products.
  always_comb begin
    am = coef_a_i[COEF_W-1] ? (~coef_a_i + 1'b1) : coef_a_i;
    bm = coef_b_i[COEF_W-1] ? (~coef_b_i + 1'b1) : coef_b_i;
    cm = coef_c_i[COEF_W-1] ? (~coef_c_i + 1'b1) : coef_c_i;
    bb_d = bm * bm;
    p_d  = am * cm;
    neg4ac_d = (coef_a_i[COEF_W-1] != coef_c_i[COEF_W-1]) && (coef_c_i != '0);
    sb1_d.zero = (coef_a_i == '0);
    sb1_d.kind = KIND_NONE;
    sb1_d.a    = coef_a_i;
    sb1_d.b    = coef_b_i;
  end

  // Stage 2: signed discriminant as sign and magnitude, then classify.
  always_comb begin
    p4   = {p_q, 2'b00};
    bbx  = {2'b00, bb_q};
    thrx = {{(RAD_W-THR_W){1'b0}}, thr_i};
    dneg = 1'b0;
    if (neg4ac_q) begin
      mag = bbx + p4;
    end else if (p4 <= bbx) begin
      mag = bbx - p4;
    end else begin
      mag  = p4 - bbx;
      dneg = 1'b1;
    end
    sb2_d = sb1_q;
    if (sb1_q.zero) begin
      sb2_d.kind = KIND_NONE;
    end else if (mag < thrx) begin
      sb2_d.kind = KIND_EQUAL;
    end else if (!dneg && (mag > thrx)) begin
      sb2_d.kind = KIND_TWO;
    end else begin
      sb2_d.kind = KIND_NONE;
    end
    rad_d = dneg ? '0 : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bb_q     <= bb_d;
      p_q      <= p_d;
      neg4ac_q <= neg4ac_d;
      sb1_q    <= sb1_d;
      rad_q    <= rad_d;
      sb2_q    <= sb2_d;
    end
  end

  assign valid_o = v2_q;
  assign rad_o   = rad_q;
  assign sb_o    = sb2_q;

endmodule

/* rtl/qrs_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt import qrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  side_t             sb_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output side_t             sb_o
);

  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  side_t             sb_q   [ROOT_W];
  logic [ROOT_W-1:0] v_q;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [RAD_W-1:0]  in_rad;
    logic [REM_W-1:0]  in_rem;
    logic [ROOT_W-1:0] in_root;
    side_t             in_sb;
    logic              in_v;
    logic [REM_W+1:0]  rem2, trial;
    logic [REM_W-1:0]  rem_d;
    logic [ROOT_W-1:0] root_d;

    if (k == 0) begin : g_first
      assign in_rad  = rad_i;
      assign in_rem  = '0;
      assign in_root = '0;
      assign in_sb   = sb_i;
      assign in_v    = valid_i;
    end else begin : g_next
      assign in_rad  = rad_q[k-1];
      assign in_rem  = rem_q[k-1];
      assign in_root = root_q[k-1];
      assign in_sb   = sb_q[k-1];
      assign in_v    = v_q[k-1];
    end

    // Bring down the next bit pair and try subtracting 4*root+1.
    always_comb begin
      rem2  = {in_rem, in_rad[RAD_W-1 -: 2]};
      trial = {2'b00, in_root, 2'b01};
      if (rem2 >= trial) begin
        rem_d  = REM_W'(rem2 - trial);
        root_d = {in_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(rem2);
        root_d = {in_root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {in_rad[RAD_W-3:0], 2'b00};
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        sb_q[k]   <= in_sb;
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign sb_o    = sb_q[ROOT_W-1];

endmodule

/* rtl/qrs_div.sv */
// Two-lane pipelined divider: (num << FRAC_BITS) / (2a), truncated and saturated.
module qrs_div import qrs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [NUM_W-1:0]  num0_i,
  input  logic signed [NUM_W-1:0]  num1_i,
  input  side_t                    sb_i,
  output logic                     valid_o,
  output logic signed [COEF_W-1:0] quo0_o,
  output logic signed [COEF_W-1:0] quo1_o,
  output side_t                    sb_o
);

  localparam int unsigned NST = QUO_W + 2;

  logic [NST-1:0]    v_q;
  side_t             sb_q [NST];
  logic [COEF_W-1:0] amag;
  logic [DEN_W-1:0]  den;
  logic [COEF_W-1:0] val_q [2];

  assign amag = sb_i.a[COEF_W-1] ? (~sb_i.a + 1'b1) : sb_i.a;
  assign den  = {amag, 1'b0};

  // Valid bits and sideband advance through prep, QUO_W steps and the final stage.
  for (genvar s = 0; s < NST; s++) begin : g_ctl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= (s == 0) ? valid_i : v_q[(s == 0) ? 0 : s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q[s] <= (s == 0) ? sb_i : sb_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [DEN_W-1:0] r_q   [QUO_W+1];
    logic [DEN_W-1:0] den_q [QUO_W+1];
    logic [QUO_W-1:0] lo_q  [QUO_W+1];
    logic [QUO_W-1:0] q_q   [QUO_W+1];
    logic             neg_q [QUO_W+1];
    logic             sat_q [QUO_W+1];
    logic [NUM_W-1:0] num;
    logic [NM_W-1:0]  nm;
    logic [N_W-1:0]   nfull;
    logic [DEN_W-1:0] hi;
    logic             neg_d, sat_d;
    logic [COEF_W-1:0] val_d;

    assign num = (l == 0) ? num0_i : num1_i;

    // Prep: magnitude, sign, saturation test and the leading partial remainder.
    always_comb begin
      nm    = num[NUM_W-1] ? NM_W'(~num + 1'b1) : NM_W'(num);
      nfull = {nm, {FRAC_BITS{1'b0}}};
      hi    = {{(DEN_W-HI_W){1'b0}}, nfull[N_W-1:QUO_W]};
      neg_d = num[NUM_W-1] != sb_i.a[COEF_W-1];
      sat_d = hi >= den;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[0]   <= hi;
        den_q[0] <= den;
        lo_q[0]  <= nfull[QUO_W-1:0];
        q_q[0]   <= '0;
        neg_q[0] <= neg_d;
        sat_q[0] <= sat_d;
      end
    end

    for (genvar s = 1; s <= QUO_W; s++) begin : g_step
      logic [DEN_W:0]   r2;
      logic             ge;
      logic [DEN_W-1:0] r_d;

      always_comb begin
        r2  = {r_q[s-1], lo_q[s-1][QUO_W-1]};
        ge  = r2 >= {1'b0, den_q[s-1]};
        r_d = ge ? DEN_W'(r2 - {1'b0, den_q[s-1]}) : DEN_W'(r2);
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[s]   <= r_d;
          den_q[s] <= den_q[s-1];
          lo_q[s]  <= {lo_q[s-1][QUO_W-2:0], 1'b0};
          q_q[s]   <= {q_q[s-1][QUO_W-2:0], ge};
          neg_q[s] <= neg_q[s-1];
          sat_q[s] <= sat_q[s-1];
        end
      end
    end

    // Final: apply sign, clamp on overflow.
    always_comb begin
      if (sat_q[QUO_W]) begin
        val_d = neg_q[QUO_W] ? ROOT_MIN : ROOT_MAX;
      end else if (neg_q[QUO_W]) begin
        val_d = ~{1'b0, q_q[QUO_W]} + 1'b1;
      end else begin
        val_d = {1'b0, q_q[QUO_W]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[l] <= val_d;
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign sb_o    = sb_q[NST-1];
  assign quo0_o  = val_q[0];
  assign quo1_o  = val_q[1];

endmodule

/* rtl/quadratic_root_solver_unit.sv */
// Top level of the quadratic root solver: pipeline control, config and output register.
//
// Real roots of a*x^2 + b*x + c for signed Q16.16 coefficients.
// Input channel: in_valid_i with coef_a_i, coef_b_i, coef_c_i; a word is
//   taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o with root_kind_o, root_low_o, root_high_o and
//   zero_leading_o; a word leaves at an edge with out_valid_o high and
//   out_stall_i low. Every input word gives exactly one output word, in order.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_data_i writes the
//   discriminant threshold (Q32.32 LSBs); cfg_ready_o is always high.
// Pipeline: 2 discriminant stages, 33 square-root stages (one root bit each),
//   1 numerator stage, 33 divider stages (31 quotient bits plus prep and sign),
//   1 output stage.
// Throughput: one word per cycle while the pipe is not frozen by a stall; the
//   bit-serial root and quotient stages set the depth, not the rate.
// Stall: when the output register holds a word that is stalled, the pipe
//   keeps advancing into empty slots and only freezes, raising in_stall_o,
//   once its last stage also holds a word. Nothing is lost or repeated.
// Reset: clears all valid bits and loads the threshold with 4295.
module quadratic_root_solver_unit import qrs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [COEF_W-1:0] coef_a_i,
  input  logic signed [COEF_W-1:0] coef_b_i,
  input  logic signed [COEF_W-1:0] coef_c_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               root_kind_o,
  output logic signed [COEF_W-1:0] root_low_o,
  output logic signed [COEF_W-1:0] root_high_o,
  output logic                     zero_leading_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [THR_W-1:0]         cfg_data_i
);

  logic [THR_W-1:0]         thr_q;
  logic                     en;
  logic                     disc_v, sqrt_v, div_v;
  logic [RAD_W-1:0]         rad;
  side_t                    disc_sb, sqrt_sb, div_sb;
  logic [ROOT_W-1:0]        root;
  logic                     num_v_q;
  side_t                    num_sb_q;
  logic signed [NUM_W-1:0]  n0_d, n1_d, n0_q, n1_q;
  logic signed [COEF_W-1:0] q0, q1;
  logic                     out_load;
  logic                     out_v_d, out_v_q;
  logic [1:0]               kind_d, kind_q;
  logic signed [COEF_W-1:0] low_d, high_d, low_q, high_q;
  logic                     zl_q;

  // Threshold register; the user must write it only while idle (not enforced here).
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  // Freeze the whole pipe only when its last stage and the output are both full and stalled.
  assign en         = !(div_v && out_v_q && out_stall_i);
  assign in_stall_o = !en;
  assign out_load   = !out_v_q || !out_stall_i;

  qrs_disc u_disc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .coef_a_i (coef_a_i),
    .coef_b_i (coef_b_i),
    .coef_c_i (coef_c_i),
    .thr_i    (thr_q),
    .valid_o  (disc_v),
    .rad_o    (rad),
    .sb_o     (disc_sb)
  );

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (disc_v),
    .rad_i   (rad),
    .sb_i    (disc_sb),
    .valid_o (sqrt_v),
    .root_o  (root),
    .sb_o    (sqrt_sb)
  );

  // Numerators -b + s and -b - s.
  always_comb begin
    n0_d = NUM_W'({2'b00, root}) - NUM_W'(sqrt_sb.b);
    n1_d = -NUM_W'(sqrt_sb.b) - NUM_W'({2'b00, root});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_v_q <= 1'b0;
    end else if (en) begin
      num_v_q <= sqrt_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n0_q     <= n0_d;
      n1_q     <= n1_d;
      num_sb_q <= sqrt_sb;
    end
  end

  qrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (num_v_q),
    .num0_i  (n0_q),
    .num1_i  (n1_q),
    .sb_i    (num_sb_q),
    .valid_o (div_v),
    .quo0_o  (q0),
    .quo1_o  (q1),
    .sb_o    (div_sb)
  );

  // Order ascending; no roots (including a zero leading coefficient) gives zeros.
  always_comb begin
    kind_d = div_sb.kind;
    if (div_sb.kind == KIND_NONE) begin
      low_d  = '0;
      high_d = '0;
    end else if (q0 > q1) begin
      low_d  = q1;
      high_d = q0;
    end else begin
      low_d  = q0;
      high_d = q1;
    end
    out_v_d = out_load ? div_v : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q <= kind_d;
      low_q  <= low_d;
      high_q <= high_d;
      zl_q   <= div_sb.zero;
    end
  end

  assign out_valid_o    = out_v_q;
  assign root_kind_o    = kind_q;
  assign root_low_o     = low_q;
  assign root_high_o    = high_q;
  assign zero_leading_o = zl_q;

  a_zero_no_roots : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_leading_o |-> root_kind_o == KIND_NONE)
    else $error("zero leading coefficient with roots reported");

  a_none_zeroed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_kind_o == KIND_NONE |-> root_low_o == '0 && root_high_o == '0)
    else $error("roots not cleared when none exist");

  a_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> root_low_o <= root_high_o)
    else $error("roots out of order");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && div_v)
    else $error("input stalled without a blocked output");

endmodule

/* tb/sv/quadratic_root_solver_unit_tb.sv */
// Testbench for the quadratic root solver: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module quadratic_root_solver_unit_tb;
  import qrs_pkg::*;

  localparam int unsigned LATENCY   = 70;
  localparam int unsigned N_RANDOM  = 1600;

  typedef struct packed {
    kind_e                    kind;
    logic signed [COEF_W-1:0] lo;
    logic signed [COEF_W-1:0] hi;
    logic                     zero;
  } roots_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [COEF_W-1:0] coef_a_i = '0;
  logic signed [COEF_W-1:0] coef_b_i = '0;
  logic signed [COEF_W-1:0] coef_c_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [1:0]               root_kind_o;
  logic signed [COEF_W-1:0] root_low_o;
  logic signed [COEF_W-1:0] root_high_o;
  logic                     zero_leading_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [THR_W-1:0]         cfg_data_i = '0;

  // Predictor copy of the threshold register.
  logic [THR_W-1:0] threshold_q = THR_RESET;

  roots_t expected_roots[$];
  int unsigned n_errors   = 0;
  int unsigned n_checked  = 0;
  int unsigned n_two      = 0;
  int unsigned n_equal    = 0;
  int unsigned n_none     = 0;
  bit          idle_tx    = 1'b1;   // random gaps on the sending side
  bit          idle_rx    = 1'b1;   // random stalls on the receiving side
  int unsigned hold_rx    = 0;      // cycles of forced receiver hold-off
  bit          hold_req   = 1'b0;   // toggle to request a hold-off
  bit          hold_ack   = 1'b0;

  always #1 clk_i = ~clk_i;

  quadratic_root_solver_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .coef_a_i, .coef_b_i, .coef_c_i,
    .out_valid_o, .out_stall_i, .root_kind_o, .root_low_o, .root_high_o,
    .zero_leading_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // Floor square root of a 66-bit magnitude, one result bit per step.
  function automatic logic [ROOT_W-1:0] isqrt66(logic [65:0] v);
    logic [67:0]       rem;
    logic [67:0]       trial;
    logic [ROOT_W-1:0] r;
    rem = '0;
    r   = '0;
    for (int i = 32; i >= 0; i--) begin
      rem   = (rem << 2) | 68'(v[2*i +: 2]);
      trial = (68'(r) << 2) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        r   = (r << 1) | 1'b1;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  // (num << FRAC_BITS) / 2|a|, truncated toward zero, then saturated.
  function automatic logic signed [COEF_W-1:0] root_div(logic signed [35:0] num,
                                                       logic signed [COEF_W-1:0] a);
    logic [35:0]  nm;
    logic [33:0]  dm;
    logic [63:0]  q;
    logic         neg;
    nm  = num[35] ? 36'(-num) : 36'(num);
    dm  = a[COEF_W-1] ? 34'(-{a[COEF_W-1], a}) << 1 : 34'(a) << 1;
    neg = num[35] != a[COEF_W-1];
    q   = (64'(nm) << FRAC_BITS) / 64'(dm);
    if (neg) begin
      if (q >= 64'h8000_0000) return ROOT_MIN;
      return COEF_W'(-q);
    end
    if (q > 64'h7FFF_FFFF) return ROOT_MAX;
    return COEF_W'(q);
  endfunction

  function automatic roots_t solve_roots(logic signed [COEF_W-1:0] a,
                                         logic signed [COEF_W-1:0] b,
                                         logic signed [COEF_W-1:0] c);
    roots_t                   r;
    logic signed [67:0]       d;
    logic [67:0]              dmag;
    logic [ROOT_W-1:0]        s;
    logic signed [35:0]       n0, n1;
    logic signed [COEF_W-1:0] r0, r1;
    r = '{kind: KIND_NONE, lo: '0, hi: '0, zero: 1'b0};
    if (a == 0) begin
      r.zero = 1'b1;
      return r;
    end
    d    = 68'(b) * 68'(b) - 68'sd4 * 68'(a) * 68'(c);
    dmag = d < 0 ? 68'(-d) : 68'(d);
    s    = '0;
    if (dmag < 68'(threshold_q)) begin
      r.kind = KIND_EQUAL;
      if (d >= 0) s = isqrt66(dmag[65:0]);
    end else if (d > 0 && dmag > 68'(threshold_q)) begin
      r.kind = KIND_TWO;
      s = isqrt66(dmag[65:0]);
    end else begin
      return r;
    end
    n0 = -36'(b) + 36'(s);
    n1 = -36'(b) - 36'(s);
    r0 = root_div(n0, a);
    r1 = root_div(n1, a);
    r.lo = (r0 > r1) ? r1 : r0;
    r.hi = (r0 > r1) ? r0 : r1;
    return r;
  endfunction

  // Offer one word; hold it until accepted. Valid stays high on return so a
  // following word can go out back to back; whoever pauses drops it.
  task automatic send_coefs(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b,
                            logic [COEF_W-1:0] c);
    while (idle_tx && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    coef_a_i   <= a;
    coef_b_i   <= b;
    coef_c_i   <= c;
    expected_roots.push_back(solve_roots(a, b, c));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_roots.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // Write the threshold while the pipe is empty.
  task automatic write_threshold(logic [THR_W-1:0] v);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    threshold_q = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver side: random stalls, or a forced hold-off while hold_rx runs.
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_rx     <= 3 * LATENCY;
      out_stall_i <= 1'b1;
    end else if (hold_rx != 0) begin
      hold_rx     <= hold_rx - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_rx && ($urandom_range(99) < 23);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    roots_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected word kind=%0d lo=%0d hi=%0d zero=%0b", $time,
                 root_kind_o, root_low_o, root_high_o, zero_leading_o);
        n_errors++;
      end else begin
        exp_r = expected_roots.pop_front();
        n_checked++;
        case (exp_r.kind)
          KIND_TWO:   n_two++;
          KIND_EQUAL: n_equal++;
          default:    n_none++;
        endcase
        if (root_kind_o !== exp_r.kind || root_low_o !== exp_r.lo ||
            root_high_o !== exp_r.hi || zero_leading_o !== exp_r.zero) begin
          $display("%0t: expected kind=%0d lo=%0d hi=%0d zero=%0b, got kind=%0d lo=%0d hi=%0d zero=%0b",
                   $time, exp_r.kind, exp_r.lo, exp_r.hi, exp_r.zero,
                   root_kind_o, root_low_o, root_high_o, zero_leading_o);
          n_errors++;
        end
      end
    end
  end

  // Random word: mostly modest coefficients, some full range.
  task automatic send_random();
    logic [COEF_W-1:0] a, b, c;
    case ($urandom_range(9))
      0, 1: begin
        a = $urandom; b = $urandom; c = $urandom;
      end
      2: begin
        // near-equal roots: b^2 close to 4ac
        a = $urandom_range(1, 65536);
        b = 2 * a;
        c = a + $urandom_range(0, 2) - 1;
      end
      default: begin
        a = $urandom_range(1, 1 << 20);
        if ($urandom_range(1)) a = -a;
        b = $urandom_range(0, 1 << 22) - (1 << 21);
        c = $urandom_range(0, 1 << 22) - (1 << 21);
      end
    endcase
    if ($urandom_range(49) == 0) a = '0;
    send_coefs(a, b, c);
  endtask

  task automatic test_directed();
    send_coefs(32'h0000_0000, 32'h0001_0000, 32'h0001_0000);  // zero a
    send_coefs(32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000);  // roots +/-1
    send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);  // double root -1
    send_coefs(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);  // no real roots
    send_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_coefs(32'h0000_0001, 32'h8000_0000, 32'h0000_0000);  // saturate
    send_coefs(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    send_coefs(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
    send_coefs(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);  // d = 0
    send_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_coefs(32'h0000_0001, 32'h0000_0000, 32'h0000_0001);  // small negative d
    send_coefs(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
    send_coefs(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
  endtask

  // Discriminant exactly at the threshold, on both sides of it.
  task automatic test_threshold_edges();
    write_threshold(32'd4);
    send_coefs(32'd1, 32'd2, 32'd0);       // d = 4: equal to threshold
    send_coefs(32'd1, 32'd0, 32'hFFFF_FFFF); // d = 4 positive
    send_coefs(32'd1, 32'd0, 32'd1);       // d = -4
    send_coefs(32'd1, 32'd1, 32'd0);       // d = 1 below
    send_coefs(32'd1, 32'd3, 32'd0);       // d = 9 above
    write_threshold(32'hFFFF_FFFF);
    send_coefs(32'd1, 32'h0001_0000, 32'd0);
    send_coefs(32'd1, 32'd0, 32'd1);
    write_threshold(32'd0);
    send_coefs(32'd1, 32'd0, 32'd0);
    send_coefs(32'd1, 32'd2, 32'd1);
  endtask

  task automatic test_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      // a long stretch with no idling on either side
      idle_tx = !(i >= n / 3 && i < n / 3 + 150);
      idle_rx = idle_tx;
      send_random();
    end
    idle_tx = 1'b1;
    idle_rx = 1'b1;
  endtask

  // Hold off the receiver long enough that the pipe fills and stalls its input.
  task automatic test_backpressure();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    hold_req = ~hold_req;
    repeat (2 * LATENCY) send_random();
    // pause the sender until every result has come back
    in_valid_i <= 1'b0;
    while (expected_roots.size() != 0) @(negedge clk_i);
    repeat (20) send_random();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_threshold_edges();
    write_threshold(THR_RESET);
    test_random(N_RANDOM / 2);
    test_backpressure();
    write_threshold(32'h0010_0000);
    test_random(N_RANDOM / 4);
    write_threshold(32'h00FF_FFFF);
    test_random(N_RANDOM / 4);
    drain_results();
    $display("checked %0d words: %0d two roots, %0d equal, %0d none or zero a",
             n_checked, n_two, n_equal, n_none);
    $display("thresholds 0, 4, reset, 2^20, 2^24-1 and all ones; backpressure and drain");
    if (n_errors == 0 && expected_roots.size() == 0) begin
      $display("quadratic_root_solver_unit: match");
    end else begin
      $display("quadratic_root_solver_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("quadratic_root_solver_unit: mismatch");
    $finish;
  end

endmodule

/* sim.f */
rtl/qrs_pkg.sv
rtl/qrs_disc.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver_unit.sv
tb/sv/quadratic_root_solver_unit_tb.sv
